// ===== hdl/guided_bilateral_filter_core_assert.svh =====
`ifndef GUIDED_BILATERAL_FILTER_CORE_ASSERT_SVH
`define GUIDED_BILATERAL_FILTER_CORE_ASSERT_SVH

// never and implication checks on clk_i, muted in reset
`ifndef SYNTHESIS
`define GBF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`define GBF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define GBF_ASSERT_NEVER(lbl, expr, msg)
`define GBF_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/gbf_pkg.sv =====
package gbf_pkg;

  localparam int HIST_DEPTH = 16392;
  localparam int ADDR_W = 15;
  localparam int WIDTH_W = 13;
  localparam int POS_W = 12;
  localparam int FILL_W = 15;
  localparam int PIX_W = 16;
  localparam int WT_W = 32;
  localparam int ACC_W = 56;
  localparam int TAPS = 25;
  localparam int SP_N = 6;
  localparam int RANGE_TABLE_SIZE = 256;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int CFG_IDX_W = 4;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4292581866;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SP0    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SP8    = 4'd7;

  typedef logic [PIX_W-1:0] rom_t [RANGE_TABLE_SIZE];

  typedef struct packed {
    logic [ADDR_W-1:0] caddr;
    logic              filt;
    logic              fend;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } wr_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CEN_A, ST_CEN_D, ST_TAP_A, ST_TAP_D, ST_TAP_M, ST_PREP, ST_DIV, ST_OUT
  } back_state_e;

  // spatial weight slot per tap, raster order over the window
  localparam logic [2:0] SP_SEL [TAPS] = '{
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd3, 3'd1, 3'd0, 3'd1, 3'd3,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5
  };

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] q2;
    logic [63:0] v;
    r  = 64'd1 << 32;
    a  = EXP_STEP_Q32;
    q2 = (EXP_STEP_Q32 * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    for (int i = 0; i < RANGE_TABLE_SIZE; i++) begin
      v = (r + 64'h8000) >> 16;
      t[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      r = (r * a + 64'h8000_0000) >> 32;
      a = (a * q2 + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam rom_t RANGE_ROM = build_rom();

endpackage

// ===== hdl/guided_bilateral_filter_core.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata source, guide; tuser kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata out_pixel; tlast frame_end
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
// an input request is taken while the job queue has room
// a border or flush pixel, when the back part is idle, leaves through ST_CEN_A, ST_CEN_D and ST_OUT
// a filtered pixel reads 25 taps through one history read port, each in ST_TAP_D
// and ST_TAP_M, then runs a 16-step shift-subtract divider
// no clearing pass after reset; stalls on m_axis back up into the job queue
`include "guided_bilateral_filter_core_assert.svh"

module guided_bilateral_filter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,   // source_pixel, guide_pixel
  input  logic                            s_axis_tuser,   // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // out_pixel
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [gbf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                     cfg_data_i
);
  import gbf_pkg::*;

  logic [WIDTH_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [PIX_W-1:0]   sp_q [SP_N];
  logic               push, full, fvalid, pop;
  job_t               job_in, job_out;
  wr_req_t            wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd768;
      sp_q[0]  <= 16'd65535;
      sp_q[1]  <= 16'd57835;
      sp_q[2]  <= 16'd51039;
      sp_q[3]  <= 16'd39750;
      sp_q[4]  <= 16'd35079;
      sp_q[5]  <= 16'd24109;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        CFG_WIDTH:         width_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT:        height_q <= cfg_data_i[WIDTH_W-1:0];
        [CFG_SP0:CFG_SP8]: sp_q[3'(cfg_idx_i - CFG_SP0)] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_q < 13'd5) ? 13'd5 : ((width_q > 13'd4096) ? 13'd4096 : width_q);
    h_eff = (height_q < 13'd5) ? 13'd5 : ((height_q > 13'd4096) ? 13'd4096 : height_q);
  end

  assign s_axis_tready = !full;

  gbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid && !full),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .w_eff_i    (w_eff),
    .h_eff_i    (h_eff),
    .job_push_o (push),
    .job_o      (job_in),
    .wr_o       (wr)
  );

  gbf_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (fvalid),
    .job_o   (job_out),
    .pop_i   (pop)
  );

  gbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (fvalid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .wr_i        (wr),
    .w_eff_i     (w_eff),
    .sp_i        (sp_q),
    .out_valid_o (m_axis_tvalid),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  `GBF_ASSERT_NEVER(a_no_push_full, push && full, "job pushed into full queue")
  `GBF_ASSERT_IMPL(a_pop_valid, pop, fvalid, "job popped from empty queue")

endmodule

// ===== hdl/gbf_front.sv =====
module gbf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_kind_i,
  input  logic [31:0]                   in_data_i,
  input  logic [gbf_pkg::WIDTH_W-1:0]   w_eff_i,
  input  logic [gbf_pkg::WIDTH_W-1:0]   h_eff_i,
  output logic                          job_push_o,
  output gbf_pkg::job_t                 job_o,
  output gbf_pkg::wr_req_t              wr_o
);
  import gbf_pkg::*;

  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [POS_W-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [FILL_W-1:0] lat, cb;
  logic [ADDR_W:0]   cdiff;
  logic              pix, flsh, emit, interior, col_end, row_end;

  always_comb begin
    pix  = in_valid_i && !in_kind_i;
    flsh = in_valid_i && in_kind_i;
    lat  = {1'b0, w_eff_i, 1'b0} + FILL_W'(2);
    emit = pix ? (fill_q >= lat) : (flsh && fill_q != '0);
    cb   = pix ? fill_q : fill_q - FILL_W'(1);
    interior = ox_q >= POS_W'(2) && ({1'b0, ox_q} + WIDTH_W'(2)) < w_eff_i &&
               oy_q >= POS_W'(2) && ({1'b0, oy_q} + WIDTH_W'(2)) < h_eff_i;
    col_end = ({1'b0, ox_q} + WIDTH_W'(1)) >= w_eff_i;
    row_end = ({1'b0, oy_q} + WIDTH_W'(1)) >= h_eff_i;
    if (wp_q >= fill_q) begin
      cdiff = {1'b0, wp_q} - {1'b0, fill_q};
    end else begin
      cdiff = {1'b0, wp_q} + (ADDR_W+1)'(HIST_DEPTH) - {1'b0, fill_q};
    end
    job_push_o  = emit;
    job_o.caddr = cdiff[ADDR_W-1:0];
    job_o.filt  = interior && cb >= lat;
    job_o.fend  = col_end && row_end;
    wr_o.en   = pix;
    wr_o.addr = wp_q;
    wr_o.data = in_data_i;

    wp_d   = wp_q;
    fill_d = fill_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    if (pix) begin
      wp_d = (wp_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
      if (!emit) fill_d = fill_q + FILL_W'(1);
    end else if (emit) begin
      fill_d = fill_q - FILL_W'(1);
    end
    if (emit) begin
      if (col_end) begin
        ox_d = '0;
        oy_d = row_end ? '0 : oy_q + POS_W'(1);
      end else begin
        ox_d = ox_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
    end
  end

endmodule

// ===== hdl/gbf_job_fifo.sv =====
module gbf_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbf_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output gbf_pkg::job_t job_o,
  input  logic          pop_i
);
  import gbf_pkg::*;

  job_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_PTR_W'(1);
      if (pop_i) rd_q <= rd_q + FIFO_PTR_W'(1);
      cnt_q <= cnt_q + (FIFO_PTR_W+1)'(push_i) - (FIFO_PTR_W+1)'(pop_i);
    end
  end

endmodule

// ===== hdl/gbf_back.sv =====
module gbf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  gbf_pkg::job_t               job_i,
  output logic                        job_pop_o,
  input  gbf_pkg::wr_req_t            wr_i,
  input  logic [gbf_pkg::WIDTH_W-1:0] w_eff_i,
  input  logic [gbf_pkg::PIX_W-1:0]   sp_i [gbf_pkg::SP_N],
  output logic                        out_valid_o,
  output logic [gbf_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                        out_last_o,
  input  logic                        out_ready_i
);
  import gbf_pkg::*;

  logic [31:0]       mem_q [HIST_DEPTH];
  logic [31:0]       rdata_q;
  back_state_e       state_q, state_d;
  job_t              job_q, job_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;
  logic [PIX_W-1:0]  cen_g_q, cen_g_d, src_q, src_d;
  logic [4:0]        k_q, k_d;
  logic [2:0]        cx_q, cx_d;
  logic [3:0]        bit_q, bit_d;
  logic [WT_W-1:0]   wt_q, wt_d;
  logic [ACC_W-1:0]  acc_s_q, acc_s_d, acc_t_q, acc_t_d, num_q, num_d, den_q, den_d;
  logic [PIX_W-1:0]  quo_q, quo_d, opix_q, opix_d;
  logic              ovalid_q, ovalid_d, olast_q, olast_d;
  logic [ADDR_W:0]   off, start, step, nxt;
  logic [PIX_W-1:0]  dd;
  logic [7:0]        ridx;
  logic [ACC_W-1:0]  trial;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    rdata_q <= mem_q[raddr_q];
  end

  always_comb begin
    off = {2'b0, w_eff_i, 1'b0} + (ADDR_W+1)'(2);
    if ({1'b0, job_q.caddr} >= off) begin
      start = {1'b0, job_q.caddr} - off;
    end else begin
      start = {1'b0, job_q.caddr} + (ADDR_W+1)'(HIST_DEPTH) - off;
    end
    step = (cx_q == 3'd4) ? {3'b0, w_eff_i} - (ADDR_W+1)'(4) : (ADDR_W+1)'(1);
    nxt  = {1'b0, raddr_q} + step;
    if (nxt >= (ADDR_W+1)'(HIST_DEPTH)) nxt = nxt - (ADDR_W+1)'(HIST_DEPTH);
    dd   = (cen_g_q >= rdata_q[31:16]) ? cen_g_q - rdata_q[31:16] : rdata_q[31:16] - cen_g_q;
    ridx = (dd > PIX_W'(RANGE_TABLE_SIZE - 1)) ? 8'hFF : dd[7:0];
    trial = den_q << bit_q;

    state_d   = state_q;
    job_d     = job_q;
    raddr_d   = raddr_q;
    cen_g_d   = cen_g_q;
    src_d     = src_q;
    k_d       = k_q;
    cx_d      = cx_q;
    bit_d     = bit_q;
    wt_d      = wt_q;
    acc_s_d   = acc_s_q;
    acc_t_d   = acc_t_q;
    num_d     = num_q;
    den_d     = den_q;
    quo_d     = quo_q;
    opix_d    = opix_q;
    olast_d   = olast_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    job_pop_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          raddr_d   = job_i.caddr;
          state_d   = ST_CEN_A;
        end
      end
      ST_CEN_A: state_d = ST_CEN_D;
      ST_CEN_D: begin
        cen_g_d   = rdata_q[31:16];
        quo_d     = rdata_q[15:0];
        if (job_q.filt) begin
          raddr_d = start[ADDR_W-1:0];
          k_d     = '0;
          cx_d    = '0;
          acc_s_d = '0;
          acc_t_d = '0;
          state_d = ST_TAP_A;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_TAP_A: state_d = ST_TAP_D;
      ST_TAP_D: begin
        wt_d    = RANGE_ROM[ridx] * sp_i[SP_SEL[k_q]];
        src_d   = rdata_q[15:0];
        raddr_d = nxt[ADDR_W-1:0];
        cx_d    = (cx_q == 3'd4) ? '0 : cx_q + 3'd1;
        state_d = ST_TAP_M;
      end
      ST_TAP_M: begin
        acc_s_d = acc_s_q + ACC_W'(src_q) * ACC_W'(wt_q);
        acc_t_d = acc_t_q + ACC_W'(wt_q);
        k_d     = k_q + 5'd1;
        state_d = (k_q == 5'(TAPS - 1)) ? ST_PREP : ST_TAP_D;
      end
      ST_PREP: begin
        if (acc_t_q == '0) begin
          state_d = ST_OUT;
        end else begin
          num_d   = (acc_s_q << 1) + acc_t_q;
          den_d   = acc_t_q << 1;
          bit_d   = 4'd15;
          quo_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (num_q >= trial) begin
          num_d        = num_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          opix_d   = quo_q;
          olast_d  = job_q.fend;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    raddr_q   <= raddr_d;
    cen_g_q   <= cen_g_d;
    src_q     <= src_d;
    k_q       <= k_d;
    cx_q      <= cx_d;
    bit_q     <= bit_d;
    wt_q      <= wt_d;
    acc_s_q   <= acc_s_d;
    acc_t_q   <= acc_t_d;
    num_q     <= num_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    opix_q    <= opix_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_pixel_o = opix_q;
  assign out_last_o  = olast_q;

endmodule

// ===== bench/guided_bilateral_filter_core_tb.sv =====
`timescale 1ns / 1ps

class gbf_scoreboard;
  localparam int HDEPTH = gbf_pkg::HIST_DEPTH;

  typedef struct {
    logic [15:0] pixel;
    logic        last;
  } pixel_exp_t;

  pixel_exp_t  expected_q[$];
  logic [15:0] src_hist[HDEPTH];
  logic [15:0] guide_hist[HDEPTH];
  logic [15:0] range_wt[gbf_pkg::RANGE_TABLE_SIZE];
  logic [12:0] width_reg, height_reg;
  logic [15:0] sp_w[6];
  int unsigned wr_ptr, fill, out_col, out_row;
  int          errors, results, filtered, flushes, pixels;

  function new();
    longint unsigned r, a, q2, v;
    r  = 64'd1 << 32;
    a  = gbf_pkg::EXP_STEP_Q32;
    q2 = (a * a + 64'h8000_0000) >> 32;
    for (int i = 0; i < gbf_pkg::RANGE_TABLE_SIZE; i++) begin
      v = (r + 64'h8000) >> 16;
      range_wt[i] = (v > 65535) ? 16'hFFFF : v[15:0];
      r = (r * a + 64'h8000_0000) >> 32;
      a = (a * q2 + 64'h8000_0000) >> 32;
    end
    for (int i = 0; i < HDEPTH; i++) begin
      src_hist[i] = '0;
      guide_hist[i] = '0;
    end
    width_reg = 13'd1024;
    height_reg = 13'd768;
    sp_w = '{16'd65535, 16'd57835, 16'd51039, 16'd39750, 16'd35079, 16'd24109};
    wr_ptr = 0; fill = 0; out_col = 0; out_row = 0;
    errors = 0; results = 0; filtered = 0; flushes = 0; pixels = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [15:0] data);
    case (idx)
      gbf_pkg::CFG_WIDTH:  width_reg = data[12:0];
      gbf_pkg::CFG_HEIGHT: height_reg = data[12:0];
      default: begin
        if (idx >= gbf_pkg::CFG_SP0 && idx <= gbf_pkg::CFG_SP8)
          sp_w[idx - gbf_pkg::CFG_SP0] = data;
      end
    endcase
  endfunction

  function int unsigned eff_w();
    return (width_reg < 5) ? 5 : (width_reg > 4096) ? 4096 : width_reg;
  endfunction

  function int unsigned eff_h();
    return (height_reg < 5) ? 5 : (height_reg > 4096) ? 4096 : height_reg;
  endfunction

  function longint unsigned spatial(int sq);
    case (sq)
      0: return sp_w[0];
      1: return sp_w[1];
      2: return sp_w[2];
      4: return sp_w[3];
      5: return sp_w[4];
      8: return sp_w[5];
      default: return 0;
    endcase
  endfunction

  function int unsigned hist_addr(int back);
    int m;
    m = back % HDEPTH;
    if (m < 0) m += HDEPTH;
    return (wr_ptr + HDEPTH - 1 - m) % HDEPTH;
  endfunction

  function void emit_oldest();
    int unsigned w, h, lat, cback, caddr, ta;
    int diff;
    logic [15:0] result;
    logic interior;
    longint unsigned sv, sw, wt;
    pixel_exp_t e;
    w = eff_w(); h = eff_h();
    lat = 2 * w + 2;
    cback = fill - 1;
    caddr = hist_addr(cback);
    result = src_hist[caddr];
    interior = out_col >= 2 && out_col + 2 < w && out_row >= 2 && out_row + 2 < h;
    if (interior && cback >= lat) begin
      sv = 0; sw = 0;
      for (int dy = -2; dy <= 2; dy++) begin
        for (int dx = -2; dx <= 2; dx++) begin
          ta = hist_addr(int'(cback) - (dy * int'(w) + dx));
          diff = int'(guide_hist[caddr]) - int'(guide_hist[ta]);
          if (diff < 0) diff = -diff;
          if (diff > 255) diff = 255;
          wt = longint'(range_wt[diff]) * spatial(dx * dx + dy * dy);
          sv += longint'(src_hist[ta]) * wt;
          sw += wt;
        end
      end
      if (sw != 0) begin
        result = 16'((2 * sv + sw) / (2 * sw));
        filtered++;
      end
    end
    e.pixel = result;
    e.last = (out_col + 1 >= w) && (out_row + 1 >= h);
    expected_q.push_back(e);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    fill--;
  endfunction

  function void note_request(logic flush, logic [15:0] src, logic [15:0] guide);
    if (flush) begin
      flushes++;
      if (fill != 0) emit_oldest();
      return;
    end
    pixels++;
    src_hist[wr_ptr] = src;
    guide_hist[wr_ptr] = guide;
    wr_ptr = (wr_ptr + 1) % HDEPTH;
    fill++;
    if (fill > 2 * eff_w() + 2) emit_oldest();
  endfunction

  function void check_result(logic [15:0] pixel, logic last);
    pixel_exp_t e;
    results++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result pixel %h last %b", $time, pixel, last);
      return;
    end
    e = expected_q.pop_front();
    if (pixel !== e.pixel) begin
      errors++;
      $display("%0t: out_pixel expected %h actual %h", $time, e.pixel, pixel);
    end
    if (last !== e.last) begin
      errors++;
      $display("%0t: frame_end expected %b actual %b", $time, e.last, last);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module guided_bilateral_filter_core_tb;
  import gbf_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // source_pixel, guide_pixel
  logic        s_axis_tuser;   // kind
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;   // out_pixel
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  gbf_scoreboard sb;
  bit calm, rx_hold;
  int sent;
  logic [15:0] guide_base;

  guided_bilateral_filter_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("tb: failure");
    $finish;
  end

  // receiver
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic write_cfg(logic [3:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic send(logic flush, logic [15:0] src, logic [15:0] guide);
    if (!calm && $urandom_range(0, 99) < 33) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= flush;
    s_axis_tdata <= {guide, src};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(flush, src, guide);
    sent++;
  endtask

  task automatic drain();
    int n;
    n = sb.fill;
    repeat (n + 1) send(1'b1, 16'($urandom), 16'($urandom));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_pixel();
    logic [15:0] src, guide;
    case ($urandom_range(0, 9))
      0: src = 16'h0000;
      1: src = 16'hFFFF;
      default: src = 16'($urandom);
    endcase
    if ($urandom_range(0, 9) == 0) guide = 16'($urandom);
    else guide = guide_base + 16'($urandom_range(0, 80));
    send(1'b0, src, guide);
  endtask

  task automatic run_frames(int nframes, int flush_pct);
    int w, h;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int f = 0; f < nframes; f++) begin
      guide_base = 16'($urandom);
      for (int p = 0; p < w * h; p++) begin
        if ($urandom_range(0, 99) < flush_pct) send(1'b1, 16'($urandom), 16'($urandom));
        send_pixel();
      end
    end
    drain();
  endtask

  initial begin
    int phase;
    logic [15:0] wsel;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    calm = 1'b0;
    rx_hold = 1'b0;
    sent = 0;
    guide_base = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest frame, extreme pixel values, flush ticks while empty
    write_cfg(CFG_WIDTH, 16'd5);
    write_cfg(CFG_HEIGHT, 16'd5);
    write_cfg(4'd15, 16'hFFFF);
    send(1'b1, 16'hFFFF, 16'hFFFF);
    send(1'b1, 16'h0000, 16'h0000);
    for (int p = 0; p < 25; p++)
      send(1'b0, (p % 2) ? 16'hFFFF : 16'h0000,
           (p % 3 == 0) ? 16'hFFFF : (p % 3 == 1) ? 16'h0000 : 16'h0010);
    drain();

    phase = 0;
    while (sent < 900) begin
      calm = (phase == 2);
      write_cfg(CFG_WIDTH, (phase == 3) ? 16'd2 : 16'($urandom_range(5, 12)));
      write_cfg(CFG_HEIGHT, (phase == 3) ? 16'd0 : 16'($urandom_range(5, 9)));
      for (int i = 0; i < 6; i++) begin
        case (phase)
          1: wsel = 16'h0000;
          4: wsel = 16'hFFFF;
          default: wsel = 16'($urandom);
        endcase
        write_cfg(CFG_SP0 + 4'(i), wsel);
      end
      if (phase == 1) rx_hold = 1'b1;
      run_frames($urandom_range(1, 3), (phase % 3 == 0) ? 8 : 2);
      phase++;
    end

    // widest line, saturated size registers
    calm = 1'b0;
    write_cfg(CFG_WIDTH, 16'hFFFF);
    write_cfg(CFG_HEIGHT, 16'h0000);
    for (int p = 0; p < 150; p++) send_pixel();
    drain();

    $display("tb: %0d pixels and %0d flush ticks sent over %0d phases", sb.pixels,
             sb.flushes, phase + 2);
    $display("tb: %0d results checked, %0d of them filtered", sb.results, sb.filtered);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
